### rtl/tween_pkg.sv
// Shared constants and types for the tween engine.
package tween_pkg;
	localparam int NUM_SLOTS_DEF = 16;
	localparam logic [7:0] SPRITE_BASE = 8'd16;
	localparam logic [7:0] NUM_SPRITES = 8'd64;
	localparam logic [7:0] FX_TARGETS = 8'd16;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [1:0] EASE_LINEAR = 2'd0;
	localparam logic [1:0] EASE_QUAD_IN = 2'd1;
	localparam logic [1:0] EASE_QUAD_OUT = 2'd2;
	localparam logic [1:0] EASE_CUBIC = 2'd3;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_SCAN  = 10'b0000000010,
		ST_WRITE = 10'b0000000100,
		ST_REPLY = 10'b0000001000,
		ST_MASK  = 10'b0000010000,
		ST_VISIT = 10'b0000100000,
		ST_DIV   = 10'b0001000000,
		ST_MUL1  = 10'b0010000000,
		ST_MUL2  = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic start;
		logic [15:0] num;
		logic [15:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [7:0] quot;
	} div_rsp_t;

	function automatic logic id_valid(input logic [7:0] id);
		logic [7:0] off;
		off = id - SPRITE_BASE;
		if (id >= SPRITE_BASE)
			return {1'b0, off[7:1]} < NUM_SPRITES;
		return id < FX_TARGETS;
	endfunction
endpackage

### rtl/tween_div.sv
// Restoring divider giving the 8-bit tween fraction, one bit per cycle.
module tween_div (
	input  logic clk,
	input  logic arst_n,
	input  tween_pkg::div_req_t req,
	output tween_pkg::div_rsp_t rsp
);
	import tween_pkg::*;

	logic busy_q;
	logic done_q;
	logic [3:0] cnt_q;
	logic [15:0] rem_q;
	logic [15:0] den_q;
	logic [7:0] quo_q;
	logic [16:0] sh;
	logic ge;

	assign sh = {rem_q, 1'b0};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 4'd8;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			quo_q <= 8'd0;
		end else if (busy_q) begin
			rem_q <= ge ? 16'(sh - {1'b0, den_q}) : sh[15:0];
			quo_q <= {quo_q[6:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
endmodule

### rtl/eased_property_tween_engine_core.sv
// Top level: slot table, sequencer, shared multiplier and output word register.
// A valid start searches the table one slot per cycle, taking the slot that
// already holds the target or else the first free slot, fills any slot found
// and replies. A tick first builds the running mask over every slot, then visits
// each slot: a slot still running goes through the divider and up to 3 passes
// through the shared 18x18 multiplier before its output word, which waits on out_stall.
module eased_property_tween_engine_core #(
	parameter int NUM_SLOTS = tween_pkg::NUM_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic cmd,
	input  logic [7:0] target,
	input  logic signed [15:0] end_value,
	input  logic [15:0] duration,
	input  logic [1:0] ease_mode,
	input  logic signed [15:0] current_value,
	output logic out_valid,
	input  logic out_stall,
	output logic write_valid,
	output logic [7:0] write_target,
	output logic signed [15:0] write_value,
	output logic [15:0] active_mask,
	output logic last
);
	import tween_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

	state_t state_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] pick_q;
	logic found_q;

	logic [NUM_SLOTS-1:0] act_q;
	logic [7:0] tgt_q [NUM_SLOTS];
	logic [1:0] ease_q [NUM_SLOTS];
	logic [15:0] start_q [NUM_SLOTS];
	logic [15:0] endv_q [NUM_SLOTS];
	logic [15:0] elap_q [NUM_SLOTS];
	logic [15:0] len_q [NUM_SLOTS];

	logic [NUM_SLOTS-1:0] pmask_q;
	logic [NUM_SLOTS-1:0] macc_q;
	logic [NUM_SLOTS-1:0] set_q;

	logic cmd_q;
	logic [7:0] itgt_q;
	logic [15:0] iend_q;
	logic [15:0] idur_q;
	logic [1:0] imode_q;
	logic [15:0] icur_q;
	logic idok_q;

	logic fin_q;
	logic [7:0] f_q;
	logic signed [35:0] prod_q;

	logic out_valid_q;
	logic wv_q;
	logic [7:0] wt_q;
	logic [15:0] wval_q;
	logic [15:0] am_q;
	logic last_q;

	logic rd_act;
	logic [7:0] rd_tgt;
	logic [1:0] rd_ease;
	logic [15:0] rd_start;
	logic [15:0] rd_end;
	logic [15:0] rd_len;
	logic [15:0] el_next;
	logic run_bit;
	logic [NUM_SLOTS-1:0] macc_next;
	logic [NUM_SLOTS-1:0] set_next;
	logic later;
	logic in_acc;
	logic out_free;
	logic out_load;
	logic rep_write;
	logic signed [17:0] mul_a;
	logic signed [17:0] mul_b;
	logic [8:0] inv;
	logic [9:0] ease_v;
	logic [16:0] diff;
	div_req_t dreq;
	div_rsp_t drsp;

	assign rd_act = act_q[idx_q];
	assign rd_tgt = tgt_q[idx_q];
	assign rd_ease = ease_q[idx_q];
	assign rd_start = start_q[idx_q];
	assign rd_end = endv_q[idx_q];
	assign rd_len = len_q[idx_q];
	assign el_next = elap_q[idx_q] + 16'd1;
	assign run_bit = rd_act && (el_next < rd_len);

	always_comb begin
		macc_next = macc_q;
		set_next = set_q;
		macc_next[idx_q] = run_bit;
		set_next[idx_q] = rd_act;
		later = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (set_q[i] && (i > int'(idx_q)))
				later = 1'b1;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = ((state_q == ST_REPLY) || (state_q == ST_OUT)) && out_free;
	assign rep_write = (cmd_q == CMD_START) && idok_q && (idur_q == 16'd0);

	assign inv = 9'd256 - {1'b0, f_q};
	assign diff = {endv_q[idx_q][15], endv_q[idx_q]} - {rd_start[15], rd_start};

	always_comb begin
		case (rd_ease)
			EASE_QUAD_IN:  ease_v = {2'b0, prod_q[15:8]};
			EASE_QUAD_OUT: ease_v = 10'(10'd256 - {1'b0, prod_q[16:8]});
			EASE_CUBIC:    ease_v = prod_q[25:16];
			default:       ease_v = {2'b0, f_q};
		endcase
	end

	always_comb begin
		mul_a = {1'b0, diff};
		mul_b = {8'b0, ease_v};
		case (state_q)
			ST_MUL1: begin
				if (rd_ease == EASE_QUAD_OUT) begin
					mul_a = {9'b0, inv};
					mul_b = {9'b0, inv};
				end else begin
					mul_a = {10'b0, f_q};
					mul_b = {10'b0, f_q};
				end
			end
			ST_MUL2: begin
				if (rd_ease == EASE_CUBIC && fin_q) begin
					mul_a = {1'b0, prod_q[16:0]};
					mul_b = {8'b0, 10'(10'd768 - {1'b0, f_q, 1'b0})};
				end else begin
					mul_a = {diff[16], diff};
					mul_b = {8'b0, ease_v};
				end
			end
			default: begin
				mul_a = {diff[16], diff};
				mul_b = {8'b0, ease_v};
			end
		endcase
	end

	assign dreq.start = (state_q == ST_VISIT) && rd_act && (el_next < rd_len);
	assign dreq.num = el_next;
	assign dreq.den = rd_len;

	tween_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q <= '0;
			pmask_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			found_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						idx_q <= '0;
						found_q <= 1'b0;
						if (cmd == CMD_TICK)
							state_q <= ST_MASK;
						else if (!id_valid(target) || duration == 16'd0)
							state_q <= ST_REPLY;
						else
							state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_act && rd_tgt == itgt_q) begin
						pick_q <= idx_q;
						found_q <= 1'b1;
						state_q <= ST_WRITE;
					end else begin
						if (!rd_act && !found_q) begin
							pick_q <= idx_q;
							found_q <= 1'b1;
						end
						if (idx_q == IDX_LAST)
							state_q <= ST_WRITE;
						else
							idx_q <= idx_q + 1'b1;
					end
				end
				ST_WRITE: begin
					if (found_q)
						act_q[pick_q] <= 1'b1;
					state_q <= ST_REPLY;
				end
				ST_REPLY: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				ST_MASK: begin
					if (idx_q == IDX_LAST) begin
						pmask_q <= macc_next;
						idx_q <= '0;
						state_q <= (set_next == '0) ? ST_REPLY : ST_VISIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_VISIT: begin
					if (!rd_act) begin
						idx_q <= idx_q + 1'b1;
					end else if (el_next >= rd_len) begin
						act_q[idx_q] <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (drsp.done)
						state_q <= (rd_ease == EASE_LINEAR) ? ST_MUL2 : ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					if (rd_ease == EASE_CUBIC && fin_q)
						state_q <= ST_MUL2;
					else
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						if (!later) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_VISIT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// fin_q marks an end write in ST_OUT; in cubic mode it marks the first
	// pass through ST_MUL2 (ease product) before the final scaling pass.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= cmd;
			itgt_q <= target;
			iend_q <= end_value;
			idur_q <= duration;
			imode_q <= ease_mode;
			icur_q <= current_value;
			idok_q <= id_valid(target);
			macc_q <= '0;
			set_q <= '0;
		end
		if (state_q == ST_MASK) begin
			macc_q <= macc_next;
			set_q <= set_next;
		end
		if (state_q == ST_WRITE && found_q) begin
			tgt_q[pick_q] <= itgt_q;
			ease_q[pick_q] <= imode_q;
			start_q[pick_q] <= icur_q;
			endv_q[pick_q] <= iend_q;
			elap_q[pick_q] <= 16'd0;
			len_q[pick_q] <= idur_q;
		end
		if (state_q == ST_VISIT && rd_act) begin
			elap_q[idx_q] <= el_next;
			fin_q <= (el_next >= rd_len);
		end
		if (state_q == ST_DIV && drsp.done) begin
			f_q <= drsp.quot;
			fin_q <= (rd_ease == EASE_CUBIC);
		end
		if (state_q == ST_MUL1) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_MUL2) begin
			if (rd_ease == EASE_CUBIC && fin_q) begin
				prod_q <= mul_a * mul_b;
				fin_q <= 1'b0;
			end else begin
				prod_q <= mul_a * mul_b;
			end
		end
		if (state_q == ST_REPLY && out_free) begin
			wv_q <= rep_write;
			wt_q <= rep_write ? itgt_q : 8'd0;
			wval_q <= rep_write ? iend_q : 16'd0;
			am_q <= 16'(pmask_q);
			last_q <= 1'b1;
		end
		if (state_q == ST_OUT && out_free) begin
			wv_q <= 1'b1;
			wt_q <= rd_tgt;
			wval_q <= fin_q ? rd_end : 16'(rd_start + prod_q[23:8]);
			am_q <= 16'(pmask_q);
			last_q <= !later;
		end
	end

	assign out_valid = out_valid_q;
	assign write_valid = wv_q;
	assign write_target = wt_q;
	assign write_value = wval_q;
	assign active_mask = am_q;
	assign last = last_q;
endmodule
